@@ rtl/mrt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants for the multipole recursion table core:
// number format, table geometry, micro-operation and jump-condition codes,
// and the control and status words between sequencer and datapath.
// ----------------------------------------------------------------------------
package mrt_pkg;

  // Q24.40 signed fixed point
  localparam int ValueBits = 64;
  localparam int FracBits  = ValueBits - 24;
  localparam int HalfBits  = ValueBits - 1;

  // table geometry: indices i, j and power e are two bits each
  localparam int IdxW     = 2;
  localparam int AddrW    = 3 * IdxW;
  localparam int MemDepth = 1 << AddrW;
  localparam int MaxAng   = 3;
  localparam int MaxRank  = 3;

  // multiplier and accumulator widths
  localparam int HalfW = ValueBits / 2;
  localparam int PartW = HalfW + 1;
  localparam int PpW   = 2 * PartW;
  localparam int ProdW = 2 * ValueBits;
  localparam int RndW  = ProdW - FracBits;
  localparam int AccW  = RndW + 4;

  // sequencer program counter
  localparam int PcW = 4;

  localparam logic [ValueBits-1:0] OneFixed = ValueBits'(1) << FracBits;

  typedef enum logic [1:0] {
    CFG_LA_MAX   = 2'd0,
    CFG_LB_MAX   = 2'd1,
    CFG_RANK_TOP = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SEED,
    OP_ENTRY_INIT,
    OP_TERM_RD,
    OP_MUL,
    OP_ROUND,
    OP_ADD,
    OP_TERM_NEXT,
    OP_WRITE,
    OP_PHASE_NEXT,
    OP_EMIT_RD,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_PHASE_EMPTY,
    COND_WEIGHT_ZERO,
    COND_REP_MORE,
    COND_TERM_MORE,
    COND_NOT_LAST,
    COND_MORE_PHASES
  } cond_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] part;    // partial product: bit 1 selects high half of a, bit 0 of b
    logic       pp_add;  // fold the registered partial product into the product
  } ctrl_t;

  typedef struct packed {
    logic phase_empty;
    logic weight_zero;
    logic rep_more;
    logic term_more;
    logic phase_last;
    logic more_phases;
  } stat_t;

endpackage

@@ rtl/mrt_seq.sv @@
// ----------------------------------------------------------------------------
// mrt_seq
// Microcode sequencer: program counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
module mrt_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mrt_pkg::stat_t stat_i,
  output mrt_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);
  import mrt_pkg::*;

  typedef struct packed {
    ctrl_t          ctrl;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  localparam logic [PcW-1:0] S_IDLE    = PcW'(0);
  localparam logic [PcW-1:0] S_ENTRY   = PcW'(1);
  localparam logic [PcW-1:0] S_TERM    = PcW'(2);
  localparam logic [PcW-1:0] S_ADD     = PcW'(9);
  localparam logic [PcW-1:0] S_TNEXT   = PcW'(10);
  localparam logic [PcW-1:0] S_PNEXT   = PcW'(12);
  localparam logic [PcW-1:0] S_EMIT_RD = PcW'(13);

  function automatic uword_t uw(input op_e op, input logic [1:0] part, input logic pp_add,
                                input cond_e cond, input logic [PcW-1:0] target);
    uword_t w;
    w.ctrl.op     = op;
    w.ctrl.part   = part;
    w.ctrl.pp_add = pp_add;
    w.cond        = cond;
    w.target      = target;
    return w;
  endfunction

  function automatic uword_t urom(input logic [PcW-1:0] addr);
    uword_t w;
    case (addr)
      4'd0:    w = uw(OP_SEED,       2'd0, 1'b0, COND_NO_START,    S_IDLE);
      4'd1:    w = uw(OP_ENTRY_INIT, 2'd0, 1'b0, COND_PHASE_EMPTY, S_PNEXT);
      4'd2:    w = uw(OP_TERM_RD,    2'd0, 1'b0, COND_WEIGHT_ZERO, S_TNEXT);
      4'd3:    w = uw(OP_MUL,        2'd0, 1'b0, COND_NEVER,       S_IDLE);
      4'd4:    w = uw(OP_MUL,        2'd1, 1'b1, COND_NEVER,       S_IDLE);
      4'd5:    w = uw(OP_MUL,        2'd2, 1'b1, COND_NEVER,       S_IDLE);
      4'd6:    w = uw(OP_MUL,        2'd3, 1'b1, COND_NEVER,       S_IDLE);
      4'd7:    w = uw(OP_NOP,        2'd0, 1'b1, COND_NEVER,       S_IDLE);
      4'd8:    w = uw(OP_ROUND,      2'd0, 1'b0, COND_NEVER,       S_IDLE);
      4'd9:    w = uw(OP_ADD,        2'd0, 1'b0, COND_REP_MORE,    S_ADD);
      4'd10:   w = uw(OP_TERM_NEXT,  2'd0, 1'b0, COND_TERM_MORE,   S_TERM);
      4'd11:   w = uw(OP_WRITE,      2'd0, 1'b0, COND_NOT_LAST,    S_TERM);
      4'd12:   w = uw(OP_PHASE_NEXT, 2'd0, 1'b0, COND_MORE_PHASES, S_ENTRY);
      4'd13:   w = uw(OP_EMIT_RD,    2'd0, 1'b0, COND_NEVER,       S_IDLE);
      4'd14:   w = uw(OP_EMIT,       2'd0, 1'b0, COND_NOT_LAST,    S_EMIT_RD);
      default: w = uw(OP_NOP,        2'd0, 1'b0, COND_ALWAYS,      S_IDLE);
    endcase
    return w;
  endfunction

  logic [PcW-1:0] pc_q, pc_d;
  uword_t         word;
  logic           take;

  assign word = urom(pc_q);

  always_comb begin
    case (word.cond)
      COND_ALWAYS:      take = 1'b1;
      COND_NO_START:    take = !start_i;
      COND_PHASE_EMPTY: take = stat_i.phase_empty;
      COND_WEIGHT_ZERO: take = stat_i.weight_zero;
      COND_REP_MORE:    take = stat_i.rep_more;
      COND_TERM_MORE:   take = stat_i.term_more;
      COND_NOT_LAST:    take = !stat_i.phase_last;
      COND_MORE_PHASES: take = stat_i.more_phases;
      default:          take = 1'b0;
    endcase
    pc_d = take ? word.target : pc_q + PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word.ctrl;
  assign busy_o = (pc_q != S_IDLE);

endmodule

@@ rtl/mrt_dp.sv @@
// ----------------------------------------------------------------------------
// mrt_dp
// Datapath: index counters, table memory, shared 33x33 multiplier folded
// over four partial products, rounding, weighted accumulation, saturation
// and the result register.
// ----------------------------------------------------------------------------
module mrt_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  mrt_pkg::ctrl_t                     ctrl_i,
  input  logic [mrt_pkg::IdxW-1:0]           la_i,
  input  logic [mrt_pkg::IdxW-1:0]           lb_i,
  input  logic [mrt_pkg::IdxW-1:0]           rk_i,
  input  logic signed [mrt_pkg::ValueBits-1:0] dist_pa_i,
  input  logic signed [mrt_pkg::ValueBits-1:0] dist_pb_i,
  input  logic signed [mrt_pkg::ValueBits-1:0] dist_po_i,
  input  logic [mrt_pkg::HalfBits-1:0]       half_inv_zeta_i,
  output mrt_pkg::stat_t                     stat_o,
  output logic                               result_valid_o,
  output logic signed [mrt_pkg::ValueBits-1:0] entry_value_o,
  output logic [mrt_pkg::IdxW-1:0]           index_a_o,
  output logic [mrt_pkg::IdxW-1:0]           index_b_o,
  output logic [mrt_pkg::IdxW-1:0]           power_o,
  output logic                               saturated_o,
  output logic                               last_o
);
  import mrt_pkg::*;

  typedef enum logic [1:0] {PH_A, PH_B, PH_C, PH_EMIT} phase_e;
  typedef enum logic [1:0] {T_LEAD, T_I, T_J, T_E} term_e;

  // control state
  phase_e          phase_q;
  term_e           term_q;
  logic [IdxW-1:0] ci_q, cj_q, ce_q;
  logic [1:0]      rep_q;
  logic            res_valid_q;

  // payload
  logic signed [ValueBits-1:0] pa_q, pb_q, po_q, h_q, opa_q;
  logic signed [PpW-1:0]       pp_q;
  logic [1:0]                  pp_sh_q;
  logic signed [ProdW-1:0]     prod_q;
  logic signed [RndW-1:0]      rnd_q;
  logic signed [AccW-1:0]      acc_q;
  logic                        flag_q;
  logic [ValueBits-1:0]        rd_val_q;
  logic                        rd_flag_q;
  logic [ValueBits:0]          tab_mem [MemDepth];

  logic [IdxW-1:0] la_e, lb_e, rk_e;
  logic [IdxW:0]   ci_inc, cj_inc, ce_inc;
  logic            at_la, at_lb, at_rk;
  logic [IdxW-1:0] ci_n, cj_n, ce_n;
  logic [IdxW-1:0] wt;
  logic [IdxW-1:0] ri, rj, re;
  logic [AddrW-1:0] rd_addr, tgt_addr, wr_addr;
  logic            rd_en, wr_en, seed;
  logic [ValueBits:0] wr_data;
  logic signed [PartW-1:0] mul_a, mul_b;
  logic signed [PpW-1:0]   pp_d;
  logic signed [ProdW-1:0] pp_ext, pp_shifted, rnd_full, rnd_sh;
  logic signed [AccW-1:0]  acc_d;
  logic                    sat_ovf;
  logic [ValueBits-1:0]    sat_val;
  logic signed [ValueBits-1:0] lead;

  // limit the ranges to the table size
  assign la_e = (la_i > IdxW'(MaxAng))  ? IdxW'(MaxAng)  : la_i;
  assign lb_e = (lb_i > IdxW'(MaxAng))  ? IdxW'(MaxAng)  : lb_i;
  assign rk_e = (rk_i > IdxW'(MaxRank)) ? IdxW'(MaxRank) : rk_i;

  assign ci_inc = {1'b0, ci_q} + (IdxW+1)'(1);
  assign cj_inc = {1'b0, cj_q} + (IdxW+1)'(1);
  assign ce_inc = {1'b0, ce_q} + (IdxW+1)'(1);
  assign at_la  = (ci_q == la_e);
  assign at_lb  = (cj_q == lb_e);
  assign at_rk  = (ce_q == rk_e);

  // status towards the sequencer
  always_comb begin
    stat_o = '0;
    case (phase_q)
      PH_A: begin
        stat_o.phase_empty = (la_e == '0);
        stat_o.phase_last  = (ci_inc == {1'b0, la_e});
      end
      PH_B: begin
        stat_o.phase_empty = (lb_e == '0);
        stat_o.phase_last  = (cj_inc == {1'b0, lb_e}) && at_la;
      end
      PH_C: begin
        stat_o.phase_empty = (rk_e == '0);
        stat_o.phase_last  = (ce_inc == {1'b0, rk_e}) && at_la && at_lb;
      end
      default: begin
        stat_o.phase_empty = 1'b0;
        stat_o.phase_last  = at_rk && at_la && at_lb;
      end
    endcase
    stat_o.weight_zero = (wt == '0);
    stat_o.rep_more    = rep_q[1];
    stat_o.term_more   = (term_q != T_E);
    stat_o.more_phases = (phase_q != PH_C);
  end

  // advance the walk: i only, then j outer over i, then e, i, j with j innermost
  always_comb begin
    ci_n = ci_q;
    cj_n = cj_q;
    ce_n = ce_q;
    case (phase_q)
      PH_A: ci_n = ci_inc[IdxW-1:0];
      PH_B: begin
        if (at_la) begin
          ci_n = '0;
          cj_n = cj_inc[IdxW-1:0];
        end else begin
          ci_n = ci_inc[IdxW-1:0];
        end
      end
      default: begin
        if (at_lb) begin
          cj_n = '0;
          if (at_la) begin
            ci_n = '0;
            ce_n = ce_inc[IdxW-1:0];
          end else begin
            ci_n = ci_inc[IdxW-1:0];
          end
        end else begin
          cj_n = cj_inc[IdxW-1:0];
        end
      end
    endcase
  end

  // term weight and source address
  always_comb begin
    ri = ci_q;
    rj = cj_q;
    re = ce_q;
    case (term_q)
      T_LEAD: wt = IdxW'(1);
      T_I: begin
        wt = ci_q;
        ri = ci_q - IdxW'(1);
      end
      T_J: begin
        wt = cj_q;
        rj = cj_q - IdxW'(1);
      end
      default: begin
        wt = ce_q;
        re = ce_q - IdxW'(1);
      end
    endcase
    rd_addr = {re, ri, rj};
  end

  always_comb begin
    case (phase_q)
      PH_A:    tgt_addr = {ce_q, ci_inc[IdxW-1:0], cj_q};
      PH_B:    tgt_addr = {ce_q, ci_q, cj_inc[IdxW-1:0]};
      default: tgt_addr = {ce_inc[IdxW-1:0], ci_q, cj_q};
    endcase
    case (phase_q)
      PH_A:    lead = pa_q;
      PH_B:    lead = pb_q;
      default: lead = po_q;
    endcase
  end

  // multiplier: one signed 33x33 partial product per cycle
  assign mul_a = ctrl_i.part[1] ? {opa_q[ValueBits-1], opa_q[ValueBits-1:HalfW]}
                                : {1'b0, opa_q[HalfW-1:0]};
  assign mul_b = ctrl_i.part[0] ? {rd_val_q[ValueBits-1], rd_val_q[ValueBits-1:HalfW]}
                                : {1'b0, rd_val_q[HalfW-1:0]};
  assign pp_d  = mul_a * mul_b;

  assign pp_ext = {{(ProdW-PpW){pp_q[PpW-1]}}, pp_q};
  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_shifted = pp_ext;
      2'd1:    pp_shifted = pp_ext <<< HalfW;
      default: pp_shifted = pp_ext <<< ValueBits;
    endcase
  end

  // round to nearest, ties up
  assign rnd_full = prod_q + (ProdW'(1) <<< (FracBits - 1));
  assign rnd_sh   = rnd_full >>> FracBits;
  assign acc_d    = acc_q + {{(AccW-RndW){rnd_q[RndW-1]}}, rnd_q};

  assign sat_ovf = !((&acc_q[AccW-1:ValueBits-1]) || !(|acc_q[AccW-1:ValueBits-1]));
  always_comb begin
    if (!sat_ovf) begin
      sat_val = acc_q[ValueBits-1:0];
    end else if (acc_q[AccW-1]) begin
      sat_val = {1'b1, {(ValueBits-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(ValueBits-1){1'b1}}};
    end
  end

  assign seed    = (ctrl_i.op == OP_SEED) && start_i;
  assign wr_en   = seed || (ctrl_i.op == OP_WRITE);
  assign wr_addr = seed ? '0 : tgt_addr;
  assign wr_data = seed ? {1'b0, OneFixed} : {flag_q | sat_ovf, sat_val};
  assign rd_en   = (ctrl_i.op == OP_TERM_RD) || (ctrl_i.op == OP_EMIT_RD);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tab_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      {rd_flag_q, rd_val_q} <= tab_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_A;
      term_q      <= T_LEAD;
      ci_q        <= '0;
      cj_q        <= '0;
      ce_q        <= '0;
      rep_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (ctrl_i.op == OP_EMIT);
      case (ctrl_i.op)
        OP_SEED: begin
          if (start_i) begin
            phase_q <= PH_A;
            term_q  <= T_LEAD;
            ci_q    <= '0;
            cj_q    <= '0;
            ce_q    <= '0;
          end
        end
        OP_ENTRY_INIT: term_q <= T_LEAD;
        OP_TERM_RD:    rep_q  <= wt;
        OP_ADD:        rep_q  <= rep_q - 2'd1;
        OP_TERM_NEXT:  term_q <= term_e'(term_q + 2'd1);
        OP_WRITE: begin
          term_q <= T_LEAD;
          ci_q   <= ci_n;
          cj_q   <= cj_n;
          ce_q   <= ce_n;
        end
        OP_PHASE_NEXT: begin
          phase_q <= phase_e'(phase_q + 2'd1);
          ci_q    <= '0;
          cj_q    <= '0;
          ce_q    <= '0;
        end
        OP_EMIT: begin
          ci_q <= ci_n;
          cj_q <= cj_n;
          ce_q <= ce_n;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pp_add) begin
      prod_q <= prod_q + pp_shifted;
    end
    case (ctrl_i.op)
      OP_SEED: begin
        if (start_i) begin
          pa_q <= dist_pa_i;
          pb_q <= dist_pb_i;
          po_q <= dist_po_i;
          h_q  <= $signed({1'b0, half_inv_zeta_i});
        end
      end
      OP_ENTRY_INIT, OP_WRITE: begin
        acc_q  <= '0;
        flag_q <= 1'b0;
      end
      OP_TERM_RD: begin
        opa_q  <= (term_q == T_LEAD) ? lead : h_q;
        prod_q <= '0;
      end
      OP_MUL: begin
        pp_q    <= pp_d;
        pp_sh_q <= 2'(ctrl_i.part[1]) + 2'(ctrl_i.part[0]);
        // pick up the source flag while its read data is fresh
        if (ctrl_i.part == 2'd0) begin
          flag_q <= flag_q | rd_flag_q;
        end
      end
      OP_ROUND: rnd_q <= rnd_sh[RndW-1:0];
      OP_ADD:   acc_q <= acc_d;
      OP_EMIT: begin
        entry_value_o <= rd_val_q;
        saturated_o   <= rd_flag_q;
        index_a_o     <= ci_q;
        index_b_o     <= cj_q;
        power_o       <= ce_q;
        last_o        <= stat_o.phase_last;
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_valid_q;

endmodule

@@ rtl/multipole_recursion_table_core.sv @@
// ----------------------------------------------------------------------------
// multipole_recursion_table_core
// One-axis multipole recursion table, Q24.40, microcoded.
// ----------------------------------------------------------------------------
// Usage: drive dist_pa_i, dist_pb_i, dist_po_i and half_inv_zeta_i and raise
// start_i; the request is taken on a rising edge with start_i high and busy_o
// low. busy_o then stays high until the whole table has been sent.
// The table is built entry by entry in three build passes on one shared
// 33x33 multiplier, four partial products per term; a further term of
// weight w is added w times, and one of weight 0 skips its multiply.
// Results then leave one per entry, each read from the table before it is
// shown, order power outer, index_a middle, index_b inner, with last_o on
// the final one.
// Each result shows for one cycle with result_valid_o; the receiver cannot
// stall and must take it then.
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) must be written only while
// busy_o is low; the block itself does not enforce this.
// Reset clears the sequencer and sets la = lb = 0, rank = 1.
// ----------------------------------------------------------------------------
module multipole_recursion_table_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [mrt_pkg::IdxW-1:0]             cfg_wdata_i,
  input  logic signed [mrt_pkg::ValueBits-1:0] dist_pa_i,
  input  logic signed [mrt_pkg::ValueBits-1:0] dist_pb_i,
  input  logic signed [mrt_pkg::ValueBits-1:0] dist_po_i,
  input  logic [mrt_pkg::HalfBits-1:0]         half_inv_zeta_i,
  output logic                                 result_valid_o,
  output logic signed [mrt_pkg::ValueBits-1:0] entry_value_o,
  output logic [mrt_pkg::IdxW-1:0]             index_a_o,
  output logic [mrt_pkg::IdxW-1:0]             index_b_o,
  output logic [mrt_pkg::IdxW-1:0]             power_o,
  output logic                                 saturated_o,
  output logic                                 last_o
);
  import mrt_pkg::*;

  logic [IdxW-1:0] la_q, lb_q, rk_q;
  ctrl_t           ctrl;
  stat_t           stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q <= '0;
      lb_q <= '0;
      rk_q <= IdxW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LA_MAX:   la_q <= cfg_wdata_i;
        CFG_LB_MAX:   lb_q <= cfg_wdata_i;
        CFG_RANK_TOP: rk_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mrt_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  mrt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .ctrl_i          (ctrl),
    .la_i            (la_q),
    .lb_i            (lb_q),
    .rk_i            (rk_q),
    .dist_pa_i       (dist_pa_i),
    .dist_pb_i       (dist_pb_i),
    .dist_po_i       (dist_po_i),
    .half_inv_zeta_i (half_inv_zeta_i),
    .stat_o          (stat),
    .result_valid_o  (result_valid_o),
    .entry_value_o   (entry_value_o),
    .index_a_o       (index_a_o),
    .index_b_o       (index_b_o),
    .power_o         (power_o),
    .saturated_o     (saturated_o),
    .last_o          (last_o)
  );

endmodule

@@ rtl/mrt_checker.sv @@
// ----------------------------------------------------------------------------
// mrt_checker
// Port-level checks on the multipole recursion table core.
// ----------------------------------------------------------------------------
module mrt_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic                                 cfg_we_i,
  input logic [1:0]                           cfg_idx_i,
  input logic [mrt_pkg::IdxW-1:0]             cfg_wdata_i,
  input logic signed [mrt_pkg::ValueBits-1:0] dist_pa_i,
  input logic signed [mrt_pkg::ValueBits-1:0] dist_pb_i,
  input logic signed [mrt_pkg::ValueBits-1:0] dist_po_i,
  input logic [mrt_pkg::HalfBits-1:0]         half_inv_zeta_i,
  input logic                                 result_valid_o,
  input logic signed [mrt_pkg::ValueBits-1:0] entry_value_o,
  input logic [mrt_pkg::IdxW-1:0]             index_a_o,
  input logic [mrt_pkg::IdxW-1:0]             index_b_o,
  input logic [mrt_pkg::IdxW-1:0]             power_o,
  input logic                                 saturated_o,
  input logic                                 last_o
);

  // results only come out of a request in flight
  a_result_in_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // each entry needs a read before it is shown: strobes never back to back
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes in consecutive cycles");

  // the final entry closes the request
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy_o)
    else $error("still busy after final entry");

endmodule

bind multipole_recursion_table_core mrt_checker u_mrt_checker (.*);

@@ dv/multipole_recursion_table_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multipole_recursion_table_core_test
// Sends one-axis distance requests through the multipole recursion table core
// under a spread of la/lb/rank settings, extremes included. Every table entry
// that comes back is checked against a bit-exact Q24.40 rebuild of the
// recursion, including rounding, saturation and the sticky saturated flag.
// ----------------------------------------------------------------------------
module multipole_recursion_table_core_test;
  import mrt_pkg::*;

  localparam int unsigned StallLimit     = 10000;
  localparam int unsigned RandomRequests = 113;
  localparam int unsigned MaxReports     = 10;

  typedef logic signed [ValueBits-1:0] fixed_t;
  typedef logic signed [ProdW-1:0]     wide_t;
  typedef logic [HalfBits-1:0]         half_t;

  localparam fixed_t FixMax  = {1'b0, {(ValueBits-1){1'b1}}};
  localparam fixed_t FixMin  = {1'b1, {(ValueBits-1){1'b0}}};
  localparam half_t  HalfMax = '1;

  typedef struct {
    fixed_t          value;
    logic [IdxW-1:0] idx_a;
    logic [IdxW-1:0] idx_b;
    logic [IdxW-1:0] pwr;
    logic            sat;
    logic            last;
  } table_entry_t;

  class multipole_table_model;
    logic [IdxW-1:0] la_max;
    logic [IdxW-1:0] lb_max;
    logic [IdxW-1:0] rank_top;
    fixed_t          tbl     [4][4][4];
    logic            sat_tbl [4][4][4];
    table_entry_t    entries_due [$];
    int unsigned     mismatch_cnt;

    function new();
      la_max       = '0;
      lb_max       = '0;
      rank_top     = IdxW'(1);
      mismatch_cnt = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [IdxW-1:0] val);
      case (idx)
        CFG_LA_MAX:   la_max = val;
        CFG_LB_MAX:   lb_max = val;
        CFG_RANK_TOP: rank_top = val;
        default: ;
      endcase
    endfunction

    // exact product, rounded to nearest with ties up, then scaled by its weight
    function wide_t rounded_term(fixed_t a, fixed_t b, int weight);
      wide_t wa, wb, w, p;
      wa = a;
      wb = b;
      w  = weight;
      p  = wa * wb;
      p  = (p + (wide_t'(1) <<< (FracBits - 1))) >>> FracBits;
      return p * w;
    endfunction

    function void make_entry(int ti, int tj, int te, int si, int sj, int se,
                             fixed_t lead, fixed_t h);
      wide_t acc, hi_lim, lo_lim;
      logic  f;
      hi_lim = {1'b0, {(ValueBits-1){1'b1}}};
      lo_lim = -hi_lim - 1;
      acc = rounded_term(lead, tbl[si][sj][se], 1);
      f   = sat_tbl[si][sj][se];
      if (si > 0) begin
        acc += rounded_term(h, tbl[si-1][sj][se], si);
        f   |= sat_tbl[si-1][sj][se];
      end
      if (sj > 0) begin
        acc += rounded_term(h, tbl[si][sj-1][se], sj);
        f   |= sat_tbl[si][sj-1][se];
      end
      if (se > 0) begin
        acc += rounded_term(h, tbl[si][sj][se-1], se);
        f   |= sat_tbl[si][sj][se-1];
      end
      if (acc > hi_lim) begin
        tbl[ti][tj][te] = FixMax;
        f = 1'b1;
      end else if (acc < lo_lim) begin
        tbl[ti][tj][te] = FixMin;
        f = 1'b1;
      end else begin
        tbl[ti][tj][te] = acc[ValueBits-1:0];
      end
      sat_tbl[ti][tj][te] = f;
    endfunction

    // build the whole table for one request and queue its entries in send order
    function void note_request(fixed_t pa, fixed_t pb, fixed_t po, half_t hz);
      fixed_t       h;
      table_entry_t ent;
      h = {1'b0, hz};
      tbl[0][0][0]     = OneFixed;
      sat_tbl[0][0][0] = 1'b0;
      for (int i = 0; i < la_max; i++)
        make_entry(i + 1, 0, 0, i, 0, 0, pa, h);
      for (int j = 0; j < lb_max; j++)
        for (int i = 0; i <= la_max; i++)
          make_entry(i, j + 1, 0, i, j, 0, pb, h);
      for (int e = 0; e < rank_top; e++)
        for (int i = 0; i <= la_max; i++)
          for (int j = 0; j <= lb_max; j++)
            make_entry(i, j, e + 1, i, j, e, po, h);
      for (int e = 0; e <= rank_top; e++)
        for (int i = 0; i <= la_max; i++)
          for (int j = 0; j <= lb_max; j++) begin
            ent.value = tbl[i][j][e];
            ent.idx_a = IdxW'(i);
            ent.idx_b = IdxW'(j);
            ent.pwr   = IdxW'(e);
            ent.sat   = sat_tbl[i][j][e];
            ent.last  = (e == rank_top && i == la_max && j == lb_max);
            entries_due.insert(entries_due.size(), ent);
          end
    endfunction

    function void check_result(table_entry_t got);
      table_entry_t want;
      if (entries_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports)
          $display("%0t: unexpected entry: value %h a %0d b %0d e %0d sat %b last %b",
                   $realtime, got.value, got.idx_a, got.idx_b, got.pwr, got.sat, got.last);
        return;
      end
      want = entries_due.pop_front();
      if (got.value !== want.value || got.idx_a !== want.idx_a ||
          got.idx_b !== want.idx_b || got.pwr !== want.pwr ||
          got.sat !== want.sat || got.last !== want.last) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("%0t: entry mismatch", $realtime);
          $display("  expected value %h a %0d b %0d e %0d sat %b last %b",
                   want.value, want.idx_a, want.idx_b, want.pwr, want.sat, want.last);
          $display("  actual   value %h a %0d b %0d e %0d sat %b last %b",
                   got.value, got.idx_a, got.idx_b, got.pwr, got.sat, got.last);
        end
      end
    endfunction
  endclass

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            start_i         = 1'b0;
  logic            busy_o;
  logic            cfg_we_i        = 1'b0;
  cfg_idx_e        cfg_idx_i       = CFG_LA_MAX;
  logic [IdxW-1:0] cfg_wdata_i     = '0;
  fixed_t          dist_pa_i       = '0;
  fixed_t          dist_pb_i       = '0;
  fixed_t          dist_po_i       = '0;
  half_t           half_inv_zeta_i = '0;
  logic            result_valid_o;
  fixed_t          entry_value_o;
  logic [IdxW-1:0] index_a_o;
  logic [IdxW-1:0] index_b_o;
  logic [IdxW-1:0] power_o;
  logic            saturated_o;
  logic            last_o;

  multipole_table_model model_h = new();
  table_entry_t         seen_entry;
  int unsigned          quiet_cycles = 0;

  multipole_recursion_table_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      seen_entry.value = entry_value_o;
      seen_entry.idx_a = index_a_o;
      seen_entry.idx_b = index_b_o;
      seen_entry.pwr   = power_o;
      seen_entry.sat   = saturated_o;
      seen_entry.last  = last_o;
      model_h.check_result(seen_entry);
    end
  end

  // end the run if neither a request nor an entry moves for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic fixed_t pick_dist();
    fixed_t raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return raw >>> $urandom_range(19, 27);
      6, 7:             return raw;
      default: begin
        case ($urandom_range(0, 4))
          0:       return FixMax;
          1:       return FixMin;
          2:       return '0;
          3:       return OneFixed;
          default: return -OneFixed;
        endcase
      end
    endcase
  endfunction

  function automatic half_t pick_half();
    half_t raw;
    raw = HalfBits'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return raw >> $urandom_range(20, 28);
      6, 7:             return raw;
      8:                return '0;
      default:          return HalfMax;
    endcase
  endfunction

  // drop start, then hold until the table is out and the core is free
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (model_h.entries_due.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic program_reg(cfg_idx_e idx, logic [IdxW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    model_h.set_reg(idx, val);
  endtask

  task automatic configure(logic [IdxW-1:0] la, logic [IdxW-1:0] lb,
                           logic [IdxW-1:0] rk);
    wait_idle();
    program_reg(CFG_LA_MAX, la);
    program_reg(CFG_LB_MAX, lb);
    program_reg(CFG_RANK_TOP, rk);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_request(fixed_t pa, fixed_t pb, fixed_t po, half_t hz,
                              int unsigned gap, bit wait_ready);
    if (gap > 0 || wait_ready) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      do @(negedge clk_i); while (wait_ready && busy_o);
      repeat (gap) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    start_i         <= 1'b1;
    dist_pa_i       <= pa;
    dist_pb_i       <= pb;
    dist_po_i       <= po;
    half_inv_zeta_i <= hz;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    model_h.note_request(pa, pb, po, hz);
  endtask

  task automatic send_random(bit no_idle);
    int unsigned gap;
    bit          wait_ready;
    gap        = no_idle ? 0 : $urandom_range(0, 12);
    wait_ready = !no_idle && ($urandom_range(0, 1) == 1);
    send_request(pick_dist(), pick_dist(), pick_dist(), pick_half(), gap, wait_ready);
  endtask

  initial begin
    int unsigned sent;
    bit          no_idle;
    sent = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: la = lb = 0, rank 1
    send_request(OneFixed, -(OneFixed >> 1), OneFixed >> 2, OneFixed >> 1, 0, 0);

    configure(2'd3, 2'd3, 2'd3);
    send_request(OneFixed >> 1, -(3 * (OneFixed >> 2)), OneFixed >> 2, OneFixed >> 1, 0, 0);
    send_request('0, '0, '0, '0, 0, 0);
    send_request(FixMax, FixMax, FixMax, HalfMax, 3, 0);
    send_request(FixMin, FixMin, FixMin, HalfMax, 0, 1);
    send_request(FixMin, FixMax, -1, '0, 0, 0);
    // exact half-LSB products: ties go up, for both signs
    send_request(64'sd1 <<< (FracBits - 1), -(64'sd1 <<< (FracBits - 1)), 64'sd1,
                 HalfBits'(1), 0, 0);
    // moderate inputs that only overflow in the deeper layers
    send_request(OneFixed << 3, OneFixed << 3, OneFixed << 3, OneFixed << 2, 5, 0);
    send_request(-(OneFixed << 1), 3 * OneFixed, -(3 * (OneFixed >> 1)), OneFixed >> 3,
                 0, 0);

    configure(2'd0, 2'd0, 2'd0);
    send_request(OneFixed, -OneFixed, FixMax, HalfMax, 0, 0);
    send_request(pick_dist(), pick_dist(), pick_dist(), pick_half(), 0, 0);

    configure(2'd3, 2'd0, 2'd0);
    send_request(-(5 * (OneFixed >> 2)), pick_dist(), pick_dist(), OneFixed, 0, 0);

    configure(2'd0, 2'd3, 2'd2);
    send_request(pick_dist(), OneFixed >> 1, -(OneFixed >> 1), OneFixed >> 2, 1, 0);

    configure(2'd1, 2'd2, 2'd3);
    send_request(pick_dist(), pick_dist(), pick_dist(), pick_half(), 0, 0);
    send_request(pick_dist(), pick_dist(), pick_dist(), pick_half(), 0, 0);

    configure(2'd3, 2'd3, 2'd0);
    send_request(pick_dist(), pick_dist(), pick_dist(), pick_half(), 0, 1);

    configure(2'd2, 2'd1, 2'd1);
    send_request(pick_dist(), pick_dist(), pick_dist(), pick_half(), 2, 0);

    while (sent < RandomRequests) begin
      configure(IdxW'($urandom_range(0, 3)), IdxW'($urandom_range(0, 3)),
                IdxW'($urandom_range(0, 3)));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 8)) begin
        send_random(no_idle);
        sent++;
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (model_h.mismatch_cnt == 0 && model_h.entries_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
